// ===== hdl/quoted_string_literal_unescaper_unit_macros.svh =====
// assertion macros for the quoted string literal unescaper unit
// used by the top level only, no other dependencies
`ifndef QUOTED_STRING_LITERAL_UNESCAPER_UNIT_MACROS_SVH
`define QUOTED_STRING_LITERAL_UNESCAPER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define QSLU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define QSLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/qslu_pkg.sv =====
// shared types, constants and decode functions for the literal unescaper
// no dependencies
`default_nettype none

package qslu_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int COUNT_OUT_W     = 16;
	localparam int SLOTS           = 3;

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_X      = 8'h78;

	typedef enum logic [3:0] {
		MODE_WAIT,
		MODE_READ,
		MODE_ESC,
		MODE_HEX1,
		MODE_HEX2,
		MODE_OCT,
		MODE_DRAIN
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_ACCEPT,
		KIND_REJECT
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} slot_t;

	// all results caused by one input byte, oldest in slot 0
	typedef struct packed {
		logic [1:0]                   n;
		slot_t [SLOTS-1:0]            slot;
		logic [COUNT_OUT_W-1:0]       count;
	} bundle_t;

	function automatic logic [7:0] simple_escape(input logic [7:0] ch);
		logic [7:0] code;
		case (ch)
			8'h61: code = 8'h07;
			8'h62: code = 8'h08;
			8'h65: code = 8'h1b;
			8'h66: code = 8'h0c;
			8'h6e: code = 8'h0a;
			8'h72: code = 8'h0d;
			8'h74: code = 8'h09;
			8'h76: code = 8'h0b;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	// valid bit on top, digit value below
	function automatic logic [4:0] hex_digit(input logic [7:0] ch);
		logic [4:0] res;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			res = {1'b1, ch[3:0]};
		end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
			res = {1'b1, ch[3:0] + 4'd9};
		end else begin
			res = 5'd0;
		end
		return res;
	endfunction

	function automatic logic is_octal(input logic [7:0] ch);
		return ch[7:3] == 5'b00110;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/qslu_front.sv =====
// front part: accepts raw bytes, runs the literal parser and packs the results of one byte
// depends on qslu_pkg
`default_nettype none

module qslu_front #(
	parameter int COUNT_WIDTH = qslu_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic             q_full,
	input  wire logic [7:0]       char_byte,
	input  wire logic             is_last,
	output qslu_pkg::bundle_t     q_data,
	output logic                  q_wr
);

	localparam int OutW = qslu_pkg::COUNT_OUT_W;

	qslu_pkg::mode_t         mode_q, mode_nx;
	logic                    quote_q, quote_nx;
	logic [7:0]              val_q, val_nx;
	logic [1:0]              dig_q, dig_nx;
	logic [COUNT_WIDTH-1:0]  cnt_q, cnt_nx, cnt_bump;
	logic [OutW-1:0]         cnt_sat;

	qslu_pkg::slot_t [qslu_pkg::SLOTS-1:0] raw;
	logic [qslu_pkg::SLOTS-1:0]            emit;
	logic                                  status, plain, wait_rej;
	logic [7:0]                            code, quote_ch, oct_val;
	logic [4:0]                            hex;
	logic [1:0]                            dig_inc, idx;
	logic                                  xfer;

	assign xfer = push && !q_full;

	generate
		if (COUNT_WIDTH > OutW) begin : g_sat
			assign cnt_sat = (|cnt_nx[COUNT_WIDTH-1:OutW]) ? '1 : cnt_nx[OutW-1:0];
		end else begin : g_ext
			assign cnt_sat = OutW'(cnt_nx);
		end
	endgenerate

	always_comb begin
		mode_nx  = mode_q;
		quote_nx = quote_q;
		val_nx   = val_q;
		dig_nx   = dig_q;
		cnt_nx   = cnt_q;
		cnt_bump = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + 1'b1;
		raw      = '0;
		emit     = '0;
		status   = 1'b0;
		plain    = 1'b0;
		wait_rej = 1'b0;
		code     = qslu_pkg::simple_escape(char_byte);
		hex      = qslu_pkg::hex_digit(char_byte);
		quote_ch = quote_q ? qslu_pkg::CH_SQUOTE : qslu_pkg::CH_DQUOTE;
		oct_val  = {val_q[4:0], 3'b000} + {5'd0, char_byte[2:0]};
		dig_inc  = dig_q + 2'd1;

		case (mode_q)
			qslu_pkg::MODE_DRAIN: begin
				if (is_last) begin
					mode_nx = qslu_pkg::MODE_WAIT;
				end
			end
			qslu_pkg::MODE_READ: begin
				cnt_nx = cnt_bump;
				plain  = 1'b1;
			end
			qslu_pkg::MODE_ESC: begin
				cnt_nx  = cnt_bump;
				mode_nx = qslu_pkg::MODE_READ;
				if (code != 8'd0) begin
					emit[0]     = 1'b1;
					raw[0].data = code;
				end else if (char_byte == qslu_pkg::CH_X) begin
					mode_nx = qslu_pkg::MODE_HEX1;
					val_nx  = 8'd0;
					dig_nx  = 2'd0;
				end else if (qslu_pkg::is_octal(char_byte)) begin
					mode_nx = qslu_pkg::MODE_OCT;
					val_nx  = {5'd0, char_byte[2:0]};
					dig_nx  = 2'd1;
				end else begin
					emit[0]     = 1'b1;
					raw[0].data = char_byte;
				end
			end
			qslu_pkg::MODE_HEX1: begin
				cnt_nx = cnt_bump;
				if (hex[4]) begin
					val_nx  = {4'd0, hex[3:0]};
					dig_nx  = 2'd1;
					mode_nx = qslu_pkg::MODE_HEX2;
				end else begin
					mode_nx = qslu_pkg::MODE_READ;
					plain   = 1'b1;
				end
			end
			qslu_pkg::MODE_HEX2: begin
				cnt_nx  = cnt_bump;
				mode_nx = qslu_pkg::MODE_READ;
				dig_nx  = 2'd0;
				emit[0] = 1'b1;
				if (hex[4]) begin
					val_nx      = {val_q[3:0], hex[3:0]};
					raw[0].data = {val_q[3:0], hex[3:0]};
				end else begin
					raw[0].data = val_q;
					plain       = 1'b1;
				end
			end
			qslu_pkg::MODE_OCT: begin
				cnt_nx = cnt_bump;
				if (qslu_pkg::is_octal(char_byte)) begin
					val_nx = oct_val;
					dig_nx = dig_inc;
					if (dig_inc == 2'd3 || dig_inc == 2'd0) begin
						emit[0]     = 1'b1;
						raw[0].data = oct_val;
						dig_nx      = 2'd0;
						mode_nx     = qslu_pkg::MODE_READ;
					end
				end else begin
					emit[0]     = 1'b1;
					raw[0].data = val_q;
					dig_nx      = 2'd0;
					mode_nx     = qslu_pkg::MODE_READ;
					plain       = 1'b1;
				end
			end
			default: begin
				cnt_nx = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
				val_nx = 8'd0;
				dig_nx = 2'd0;
				if (char_byte == qslu_pkg::CH_SQUOTE || char_byte == qslu_pkg::CH_DQUOTE) begin
					quote_nx = (char_byte == qslu_pkg::CH_SQUOTE);
					mode_nx  = qslu_pkg::MODE_READ;
				end else begin
					emit[1]     = 1'b1;
					raw[1].kind = qslu_pkg::KIND_REJECT;
					status      = 1'b1;
					wait_rej    = 1'b1;
				end
			end
		endcase

		if (plain) begin
			if (char_byte == qslu_pkg::CH_BSLASH) begin
				mode_nx = qslu_pkg::MODE_ESC;
			end else if (char_byte == quote_ch) begin
				emit[1]     = 1'b1;
				raw[1].kind = qslu_pkg::KIND_ACCEPT;
				status      = 1'b1;
			end else begin
				emit[1]     = 1'b1;
				raw[1].data = char_byte;
			end
		end

		if (mode_q != qslu_pkg::MODE_DRAIN) begin
			if (!status && is_last) begin
				emit[2]     = 1'b1;
				raw[2].kind = qslu_pkg::KIND_REJECT;
				status      = 1'b1;
			end
			if (status) begin
				mode_nx = is_last ? qslu_pkg::MODE_WAIT : qslu_pkg::MODE_DRAIN;
				dig_nx  = 2'd0;
			end
		end

		// pack the emitted results into the lowest slots
		q_data = '0;
		idx    = 2'd0;
		for (int i = 0; i < qslu_pkg::SLOTS; i++) begin
			if (emit[i]) begin
				q_data.slot[idx] = raw[i];
				idx              = idx + 2'd1;
			end
		end
		q_data.n     = idx;
		q_data.count = wait_rej ? '0 : cnt_sat;
		q_wr         = xfer && (idx != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= qslu_pkg::MODE_WAIT;
			quote_q <= 1'b0;
			val_q   <= 8'd0;
			dig_q   <= 2'd0;
			cnt_q   <= '0;
		end else if (xfer) begin
			mode_q  <= mode_nx;
			quote_q <= quote_nx;
			val_q   <= val_nx;
			dig_q   <= dig_nx;
			cnt_q   <= cnt_nx;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/qslu_fifo.sv =====
// short queue of result bundles between front and back
// depends on qslu_pkg
`default_nettype none

module qslu_fifo #(
	parameter int QUEUE_DEPTH = qslu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire qslu_pkg::bundle_t wr_data,
	input  wire logic              rd,
	output qslu_pkg::bundle_t      rd_data,
	output logic                   full,
	output logic                   empty
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int LvlW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
	localparam logic [LvlW-1:0] LvlFull = LvlW'(QUEUE_DEPTH);

	qslu_pkg::bundle_t mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [LvlW-1:0]   level_q;
	logic              do_wr, do_rd;

	assign full    = (level_q == LvlFull);
	assign empty   = (level_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/qslu_back.sv =====
// back part: holds one bundle and hands its results out one transfer at a time
// depends on qslu_pkg
`default_nettype none

module qslu_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire qslu_pkg::bundle_t q_data,
	input  wire logic             q_empty,
	output logic                  q_rd,
	input  wire logic             pop,
	output logic                  empty,
	output qslu_pkg::kind_t       kind,
	output logic [7:0]            data,
	output logic [qslu_pkg::COUNT_OUT_W-1:0] count,
	output logic                  last
);

	qslu_pkg::bundle_t cur_q;
	logic              val_q;
	logic [1:0]        idx_q;
	qslu_pkg::slot_t   sl;
	logic              load;

	assign sl    = cur_q.slot[idx_q];
	assign empty = !val_q;
	assign kind  = sl.kind;
	assign data  = sl.data;
	assign count = (sl.kind == qslu_pkg::KIND_BYTE) ? '0 : cur_q.count;
	assign last  = (idx_q == cur_q.n - 2'd1);
	assign load  = !val_q || (pop && last);
	assign q_rd  = load && !q_empty;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			val_q <= !q_empty;
			idx_q <= 2'd0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/quoted_string_literal_unescaper_unit.sv =====
// Decodes a quoted literal taken one raw byte per transfer and hands out decoded bytes and a
// final accept or reject status. The front takes one byte every cycle while the bundle queue
// has room; all results of a byte travel as one bundle, and the back hands out one result per
// cycle with pop held; a byte with k results holds the back until all k are popped.
// Sustained rate is one byte per cycle when bytes cause at most one result each; QUEUE_DEPTH
// bundles absorb bursts. Depends on qslu_pkg, qslu_front, qslu_fifo, qslu_back, macros header.
`default_nettype none

`include "quoted_string_literal_unescaper_unit_macros.svh"

module quoted_string_literal_unescaper_unit #(
	parameter int COUNT_WIDTH = qslu_pkg::COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = qslu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  char_byte,
	input  wire logic        is_last,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       result_kind,
	output logic [7:0]       out_byte,
	output logic [15:0]      consumed_count,
	output logic             last_of_run
);

	qslu_pkg::bundle_t wr_data, rd_data;
	qslu_pkg::kind_t   kind;
	logic              q_wr, q_rd, q_full, q_empty;

	assign full        = q_full;
	assign result_kind = kind;

	qslu_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.q_full   (q_full),
		.char_byte(char_byte),
		.is_last  (is_last),
		.q_data   (wr_data),
		.q_wr     (q_wr)
	);

	qslu_fifo #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_data(wr_data),
		.rd     (q_rd),
		.rd_data(rd_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	qslu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (rd_data),
		.q_empty(q_empty),
		.q_rd   (q_rd),
		.pop    (pop),
		.empty  (empty),
		.kind   (kind),
		.data   (out_byte),
		.count  (consumed_count),
		.last   (last_of_run)
	);

	`QSLU_ASSERT_IMPL(a_status_last, clk, arst_n, !empty && kind != qslu_pkg::KIND_BYTE, last_of_run, "status result not last of its run")
	`QSLU_ASSERT_IMPL(a_byte_count, clk, arst_n, !empty && kind == qslu_pkg::KIND_BYTE, consumed_count == 16'd0, "decoded byte carries a count")
	`QSLU_ASSERT_IMPL(a_no_overflow, clk, arst_n, q_wr, !q_full, "bundle written into a full queue")
	`QSLU_ASSERT_NEXT(a_refill, clk, arst_n, empty && !q_empty, !empty, "back did not take a waiting bundle")

endmodule

`default_nettype wire
